// ----- rtl/drld_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the data run list decoder.
// Used by drld_core, drld_fifo and data_run_list_decoder; no dependencies.
package drld_pkg;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_OFFSET,
    PH_DONE
  } phase_t;

  localparam logic KIND_RUN = 1'b0;
  localparam logic KIND_END = 1'b1;

  localparam logic [2:0] CAUSE_NONE        = 3'd0;
  localparam logic [2:0] CAUSE_ZERO_HEADER = 3'd0;
  localparam logic [2:0] CAUSE_ZERO_LENGTH = 3'd1;
  localparam logic [2:0] CAUSE_TRUNCATED   = 3'd2;
  localparam logic [2:0] CAUSE_LIMIT       = 3'd3;
  localparam logic [2:0] CAUSE_EXHAUSTED   = 3'd4;

  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoLvlW  = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic        kind;
    logic [63:0] start;
    logic [63:0] count;
    logic [6:0]  runs;
    logic [2:0]  cause;
    logic        last;
  } result_t;

  // A byte yields no result, one result, or a run followed by an end.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

// ----- rtl/drld_core.sv -----
`timescale 1ns / 1ps
// Per-byte decode state and next-state logic for the run list decoder.
// Depends on drld_pkg.
module drld_core #(
  parameter int MAX_RUN_COUNT = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    take,
  input  logic [7:0]              list_byte,
  input  logic                    final_byte,
  input  logic [6:0]              run_limit,
  output drld_pkg::push_t         push,
  output drld_pkg::result_t       res0,
  output drld_pkg::result_t       res1,
  output drld_pkg::phase_t        phase
);

  localparam logic [8:0] MaxRuns = 9'(MAX_RUN_COUNT);

  drld_pkg::phase_t phase_next;
  logic [3:0]  length_bytes_left, length_bytes_left_next;
  logic [3:0]  offset_bytes_left, offset_bytes_left_next;
  logic [3:0]  field_byte_index, field_byte_index_next;
  logic [3:0]  offset_width_bytes, offset_width_bytes_next;
  logic [63:0] length_accumulator, length_accumulator_next;
  logic [63:0] offset_accumulator, offset_accumulator_next;
  logic [63:0] running_cluster, running_cluster_next;
  logic [6:0]  run_counter, run_counter_next;

  logic [63:0] byte_shifted;
  logic [63:0] length_merged;
  logic [63:0] offset_merged;
  logic [63:0] offset_full;
  logic [63:0] cluster_sum;
  logic [8:0]  limit_eff;
  logic        limit_hit;
  logic        clear_list;
  logic [3:0]  length_left_dec;
  logic [3:0]  offset_left_dec;
  logic [6:0]  run_counter_inc;

  function automatic logic [63:0] sign_fill(logic [63:0] v, logic [2:0] w);
    logic [63:0] r;
    case (w)
      3'd1: r = {{56{v[7]}},  v[7:0]};
      3'd2: r = {{48{v[15]}}, v[15:0]};
      3'd3: r = {{40{v[23]}}, v[23:0]};
      3'd4: r = {{32{v[31]}}, v[31:0]};
      3'd5: r = {{24{v[39]}}, v[39:0]};
      3'd6: r = {{16{v[47]}}, v[47:0]};
      3'd7: r = {{8{v[55]}},  v[55:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  always_comb begin
    byte_shifted  = 64'(list_byte) << {field_byte_index[2:0], 3'b000};
    length_merged = field_byte_index[3] ? length_accumulator
                                        : (length_accumulator | byte_shifted);
    offset_merged = field_byte_index[3] ? offset_accumulator
                                        : (offset_accumulator | byte_shifted);
    offset_full   = offset_width_bytes[3] ? offset_merged
                                          : sign_fill(offset_merged, offset_width_bytes[2:0]);
    cluster_sum   = running_cluster + offset_full;
    limit_eff     = ({2'b00, run_limit} < MaxRuns) ? {2'b00, run_limit} : MaxRuns;
    limit_hit     = {2'b00, run_counter} >= limit_eff;
    length_left_dec = length_bytes_left - 4'd1;
    offset_left_dec = offset_bytes_left - 4'd1;
    run_counter_inc = run_counter + 7'd1;
  end

  always_comb begin
    phase_next              = phase;
    length_bytes_left_next  = length_bytes_left;
    offset_bytes_left_next  = offset_bytes_left;
    field_byte_index_next   = field_byte_index;
    offset_width_bytes_next = offset_width_bytes;
    length_accumulator_next = length_accumulator;
    offset_accumulator_next = offset_accumulator;
    running_cluster_next    = running_cluster;
    run_counter_next        = run_counter;
    clear_list              = 1'b0;
    push                    = '0;
    res0                    = '0;
    res1                    = '0;
    res0.runs               = run_counter;

    // Second result is only ever the end after a run that closes the list.
    res1.kind  = drld_pkg::KIND_END;
    res1.cause = drld_pkg::CAUSE_EXHAUSTED;
    res1.last  = 1'b1;
    res1.runs  = run_counter_inc;

    case (phase)
      drld_pkg::PH_HEADER: begin
        if (list_byte == 8'h00 || limit_hit || list_byte[3:0] == 4'h0) begin
          push.first = 1'b1;
          res0.kind  = drld_pkg::KIND_END;
          res0.last  = 1'b1;
          if (list_byte == 8'h00) begin
            res0.cause = drld_pkg::CAUSE_ZERO_HEADER;
          end else if (limit_hit) begin
            res0.cause = drld_pkg::CAUSE_LIMIT;
          end else begin
            res0.cause = drld_pkg::CAUSE_ZERO_LENGTH;
          end
          phase_next = drld_pkg::PH_DONE;
          clear_list = final_byte;
        end else begin
          length_bytes_left_next  = list_byte[3:0];
          offset_bytes_left_next  = list_byte[7:4];
          offset_width_bytes_next = list_byte[7:4];
          field_byte_index_next   = 4'd0;
          length_accumulator_next = 64'd0;
          offset_accumulator_next = 64'd0;
          phase_next              = drld_pkg::PH_LENGTH;
          if (final_byte) begin
            push.first = 1'b1;
            res0.kind  = drld_pkg::KIND_END;
            res0.cause = drld_pkg::CAUSE_TRUNCATED;
            res0.last  = 1'b1;
            clear_list = 1'b1;
          end
        end
      end
      drld_pkg::PH_LENGTH: begin
        length_accumulator_next = length_merged;
        field_byte_index_next   = field_byte_index + 4'd1;
        length_bytes_left_next  = length_left_dec;
        if (length_left_dec == 4'd0 && offset_bytes_left == 4'd0) begin
          // Run without offset: starts at the running cluster.
          field_byte_index_next = 4'd0;
          run_counter_next      = run_counter_inc;
          phase_next            = drld_pkg::PH_HEADER;
          push.first            = 1'b1;
          res0.kind             = drld_pkg::KIND_RUN;
          res0.start            = running_cluster;
          res0.count            = length_merged;
          res0.runs             = run_counter_inc;
          push.second           = final_byte;
          clear_list            = final_byte;
        end else begin
          if (length_left_dec == 4'd0) begin
            field_byte_index_next = 4'd0;
            phase_next            = drld_pkg::PH_OFFSET;
          end
          if (final_byte) begin
            push.first = 1'b1;
            res0.kind  = drld_pkg::KIND_END;
            res0.cause = drld_pkg::CAUSE_TRUNCATED;
            res0.last  = 1'b1;
            clear_list = 1'b1;
          end
        end
      end
      drld_pkg::PH_OFFSET: begin
        offset_accumulator_next = offset_merged;
        field_byte_index_next   = field_byte_index + 4'd1;
        offset_bytes_left_next  = offset_left_dec;
        if (offset_left_dec == 4'd0) begin
          field_byte_index_next   = 4'd0;
          offset_accumulator_next = offset_full;
          running_cluster_next    = cluster_sum;
          run_counter_next        = run_counter_inc;
          phase_next              = drld_pkg::PH_HEADER;
          push.first              = 1'b1;
          res0.kind               = drld_pkg::KIND_RUN;
          res0.start              = cluster_sum;
          res0.count              = length_accumulator;
          res0.runs               = run_counter_inc;
          push.second             = final_byte;
          clear_list              = final_byte;
        end else if (final_byte) begin
          push.first = 1'b1;
          res0.kind  = drld_pkg::KIND_END;
          res0.cause = drld_pkg::CAUSE_TRUNCATED;
          res0.last  = 1'b1;
          clear_list = 1'b1;
        end
      end
      default: begin
        clear_list = final_byte;
      end
    endcase

    if (clear_list) begin
      phase_next              = drld_pkg::PH_HEADER;
      length_bytes_left_next  = 4'd0;
      offset_bytes_left_next  = 4'd0;
      field_byte_index_next   = 4'd0;
      offset_width_bytes_next = 4'd0;
      length_accumulator_next = 64'd0;
      offset_accumulator_next = 64'd0;
      running_cluster_next    = 64'd0;
      run_counter_next        = 7'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= drld_pkg::PH_HEADER;
      length_bytes_left  <= 4'd0;
      offset_bytes_left  <= 4'd0;
      field_byte_index   <= 4'd0;
      offset_width_bytes <= 4'd0;
      length_accumulator <= 64'd0;
      offset_accumulator <= 64'd0;
      running_cluster    <= 64'd0;
      run_counter        <= 7'd0;
    end else if (take) begin
      phase              <= phase_next;
      length_bytes_left  <= length_bytes_left_next;
      offset_bytes_left  <= offset_bytes_left_next;
      field_byte_index   <= field_byte_index_next;
      offset_width_bytes <= offset_width_bytes_next;
      length_accumulator <= length_accumulator_next;
      offset_accumulator <= offset_accumulator_next;
      running_cluster    <= running_cluster_next;
      run_counter        <= run_counter_next;
    end
  end

endmodule

// ----- rtl/drld_fifo.sv -----
`timescale 1ns / 1ps
// Small result queue that takes up to two results per cycle and hands out one.
// Depends on drld_pkg.
module drld_fifo (
  input  logic                               clk,
  input  logic                               rst,
  input  drld_pkg::push_t                    push,
  input  drld_pkg::result_t                  entry0,
  input  drld_pkg::result_t                  entry1,
  input  logic                               pop,
  output drld_pkg::result_t                  head,
  output logic                               not_empty,
  output logic [drld_pkg::FifoLvlW-1:0]      level
);

  drld_pkg::result_t mem [drld_pkg::FifoDepth];

  logic [drld_pkg::FifoPtrW-1:0] wr_ptr, wr_ptr_next;
  logic [drld_pkg::FifoPtrW-1:0] rd_ptr, rd_ptr_next;
  logic [drld_pkg::FifoLvlW-1:0] level_next;
  logic [drld_pkg::FifoLvlW-1:0] push_n;

  always_comb begin
    push_n      = drld_pkg::FifoLvlW'(push.first) + drld_pkg::FifoLvlW'(push.second);
    wr_ptr_next = wr_ptr + drld_pkg::FifoPtrW'(push_n);
    rd_ptr_next = rd_ptr + drld_pkg::FifoPtrW'(pop);
    level_next  = level + push_n - drld_pkg::FifoLvlW'(pop);
    head        = mem[rd_ptr];
    not_empty   = (level != '0);
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wr_ptr] <= entry0;
    end
    if (push.second) begin
      mem[wr_ptr + drld_pkg::FifoPtrW'(1)] <= entry1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      level  <= level_next;
    end
  end

endmodule

// ----- rtl/data_run_list_decoder.sv -----
`timescale 1ns / 1ps
// Streaming run list decoder: one list byte per transfer, runs and ends out.
// A result is registered in the result queue by the byte transfer that caused it and is offered from the queue head.
// Throughput: one byte per cycle; the 4-entry result queue stalls input while it
// has fewer than two free entries, so output stall alone limits the byte rate.
// Reset (rst, synchronous): decode state cleared, run_limit = 64, queue empty.
// Depends on drld_pkg, drld_core and drld_fifo.
module data_run_list_decoder #(
  parameter int MAX_RUN_COUNT = 64
) (
  input  logic               clk,
  input  logic               rst,
  // configuration: run_limit
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data,
  // input byte channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         list_byte,
  input  logic               final_byte,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               result_kind,
  output logic signed [63:0] run_start_cluster,
  output logic [63:0]        run_cluster_count,
  output logic [6:0]         runs_so_far,
  output logic [2:0]         end_cause,
  output logic               last_result
);

  logic [6:0]        run_limit;
  logic              in_xfer;
  logic              out_xfer;
  drld_pkg::push_t   push;
  drld_pkg::result_t res0;
  drld_pkg::result_t res1;
  drld_pkg::result_t head;
  drld_pkg::phase_t  phase;
  logic [drld_pkg::FifoLvlW-1:0] level;

  // Hold the run limit; software must write it only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      run_limit <= 7'd64;
    end else if (cfg_wr_en) begin
      run_limit <= cfg_wr_data;
    end
  end

  // Stall input whenever the queue cannot absorb a worst-case byte (two results).
  assign in_stall = (level > drld_pkg::FifoLvlW'(drld_pkg::FifoDepth - 2));
  assign in_xfer  = in_valid & ~in_stall;
  assign out_xfer = out_valid & ~out_stall;

  // Decode each transferred byte in one pass against the held list state.
  drld_core #(
    .MAX_RUN_COUNT (MAX_RUN_COUNT)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .take       (in_xfer),
    .list_byte  (list_byte),
    .final_byte (final_byte),
    .run_limit  (run_limit),
    .push       (push),
    .res0       (res0),
    .res1       (res1),
    .phase      (phase)
  );

  // Queue results; only bytes that transfer may push.
  drld_pkg::push_t push_gated;
  always_comb begin
    push_gated.first  = push.first & in_xfer;
    push_gated.second = push.second & in_xfer;
  end

  drld_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push_gated),
    .entry0    (res0),
    .entry1    (res1),
    .pop       (out_xfer),
    .head      (head),
    .not_empty (out_valid),
    .level     (level)
  );

  // Drive the result fields straight from the queue head.
  assign result_kind       = head.kind;
  assign run_start_cluster = $signed(head.start);
  assign run_cluster_count = head.count;
  assign runs_so_far       = head.runs;
  assign end_cause         = head.cause;
  assign last_result       = head.last;

  // Second result is only the end that follows a run.
  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    push_gated.second |-> push_gated.first)
    else $error("second result pushed without a first");

  // Queue never holds more than its depth.
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= drld_pkg::FifoLvlW'(drld_pkg::FifoDepth))
    else $error("result queue overflow");

  // A final byte always leaves the decoder waiting for a fresh header.
  a_final_restarts: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && final_byte) |=> (phase == drld_pkg::PH_HEADER))
    else $error("final byte did not restart the list");

  // End results carry the last flag, run results carry a nonzero runs_so_far.
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result_kind == last_result))
    else $error("last flag does not match result kind");

  a_run_counted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == drld_pkg::KIND_RUN) |-> (runs_so_far != 7'd0))
    else $error("run result with zero run count");

endmodule

// ----- test/data_run_list_decoder_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for data_run_list_decoder: run list bytes in, runs and ends out.
// Depends on drld_pkg and the data_run_list_decoder RTL; reads no files.
module data_run_list_decoder_tb;

  localparam int MaxRuns    = 64;    // MAX_RUN_COUNT of the instance
  localparam int IdleLimit  = 4000;  // cycles without any transfer before giving up
  localparam int HoldCycles = 400;   // long result hold-off
  localparam int RandBytes  = 250;   // decoded bytes in the random part

  logic               clk;
  logic               rst         = 1'b1;
  logic               cfg_wr_en   = 1'b0;
  logic [6:0]         cfg_wr_data = 7'd0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [7:0]         list_byte   = 8'd0;
  logic               final_byte  = 1'b0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic               result_kind;
  logic signed [63:0] run_start_cluster;
  logic [63:0]        run_cluster_count;
  logic [6:0]         runs_so_far;
  logic [2:0]         end_cause;
  logic               last_result;

  data_run_list_decoder #(
    .MAX_RUN_COUNT(MaxRuns)
  ) u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .list_byte        (list_byte),
    .final_byte       (final_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_kind      (result_kind),
    .run_start_cluster(run_start_cluster),
    .run_cluster_count(run_cluster_count),
    .runs_so_far      (runs_so_far),
    .end_cause        (end_cause),
    .last_result      (last_result)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Decoder shadow state. Updated once per accepted byte transfer, in the
  // sender's process, so results are queued before the block can emit them.
  // ---------------------------------------------------------------------------
  drld_pkg::phase_t lst_phase;
  logic [3:0]  len_left;
  logic [3:0]  off_left;
  logic [3:0]  field_idx;
  logic [3:0]  off_width;
  logic [63:0] len_acc;
  logic [63:0] off_acc;
  logic [63:0] cluster_base;
  logic [6:0]  run_count;
  logic [6:0]  limit_reg;
  int          bytes_decoded;

  drld_pkg::result_t results_due[$];
  drld_pkg::result_t want;
  int          error_count;

  // Sender pacing and the list under construction.
  logic [7:0]  list_bytes[$];
  bit          offering;
  bit          gaps_on;
  int          burst_left;

  // Receiver stall pattern and long hold-off.
  bit          hold_request;
  int          hold_left;
  int          stall_mode;
  logic [7:0]  stall_tick;
  int          idle_cycles;

  function automatic void restart_list();
    lst_phase    = drld_pkg::PH_HEADER;
    len_left     = '0;
    off_left     = '0;
    field_idx    = '0;
    off_width    = '0;
    len_acc      = '0;
    off_acc      = '0;
    cluster_base = '0;
    run_count    = '0;
  endfunction

  function automatic void queue_result(logic kind, logic [63:0] start, logic [63:0] count,
                                       logic [2:0] cause, logic last);
    drld_pkg::result_t r;
    r.kind  = kind;
    r.start = start;
    r.count = count;
    r.runs  = run_count;
    r.cause = cause;
    r.last  = last;
    results_due.push_back(r);
  endfunction

  // Queue the end of the list; a final byte also starts a fresh list.
  function automatic void close_list(logic [2:0] cause, logic fin);
    queue_result(drld_pkg::KIND_END, '0, '0, cause, 1'b1);
    if (fin) restart_list();
    else lst_phase = drld_pkg::PH_DONE;
  endfunction

  function automatic void emit_run(logic fin);
    run_count = run_count + 7'd1;
    queue_result(drld_pkg::KIND_RUN, cluster_base, len_acc, drld_pkg::CAUSE_NONE, 1'b0);
    lst_phase = drld_pkg::PH_HEADER;
    if (fin) close_list(drld_pkg::CAUSE_EXHAUSTED, 1'b1);
  endfunction

  function automatic void decode_list_byte(logic [7:0] b, logic fin);
    logic [6:0] eff_limit;
    int         w;
    eff_limit = (limit_reg < 7'(MaxRuns)) ? limit_reg : 7'(MaxRuns);
    if (lst_phase != drld_pkg::PH_DONE) bytes_decoded++;
    case (lst_phase)
      drld_pkg::PH_HEADER: begin
        if (b == 8'h00) close_list(drld_pkg::CAUSE_ZERO_HEADER, fin);
        else if (run_count >= eff_limit) close_list(drld_pkg::CAUSE_LIMIT, fin);
        else if (b[3:0] == 4'h0) close_list(drld_pkg::CAUSE_ZERO_LENGTH, fin);
        else begin
          len_left  = b[3:0];
          off_left  = b[7:4];
          off_width = b[7:4];
          field_idx = '0;
          len_acc   = '0;
          off_acc   = '0;
          lst_phase = drld_pkg::PH_LENGTH;
          if (fin) close_list(drld_pkg::CAUSE_TRUNCATED, 1'b1);
        end
      end
      drld_pkg::PH_LENGTH: begin
        // Bytes past the eighth are consumed but do not change the field.
        if (field_idx < 4'd8) len_acc |= 64'(b) << (8 * field_idx);
        field_idx = field_idx + 4'd1;
        len_left  = len_left - 4'd1;
        if (len_left == 4'd0) begin
          field_idx = '0;
          if (off_left == 4'd0) begin
            emit_run(fin);
            return;
          end
          lst_phase = drld_pkg::PH_OFFSET;
        end
        if (fin) close_list(drld_pkg::CAUSE_TRUNCATED, 1'b1);
      end
      drld_pkg::PH_OFFSET: begin
        if (field_idx < 4'd8) off_acc |= 64'(b) << (8 * field_idx);
        field_idx = field_idx + 4'd1;
        off_left  = off_left - 4'd1;
        if (off_left == 4'd0) begin
          // Sign-extend from the top byte present; a full eight-byte offset
          // (or wider) already carries its sign in bit 63.
          w = (off_width < 4'd8) ? int'(off_width) : 8;
          field_idx = '0;
          if (w < 8 && off_acc[8 * w - 1]) off_acc |= ~64'd0 << (8 * w);
          cluster_base = cluster_base + off_acc;
          emit_run(fin);
          return;
        end
        if (fin) close_list(drld_pkg::CAUSE_TRUNCATED, 1'b1);
      end
      default: begin
        if (fin) restart_list();
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    if (error_count < 40)
      $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, exp_val);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        report_mismatch("result with nothing due", 64'(result_kind), '0);
      end else begin
        want = results_due.pop_front();
        if (result_kind !== want.kind)
          report_mismatch("result_kind", 64'(result_kind), 64'(want.kind));
        if (run_start_cluster !== want.start)
          report_mismatch("run_start_cluster", run_start_cluster, want.start);
        if (run_cluster_count !== want.count)
          report_mismatch("run_cluster_count", run_cluster_count, want.count);
        if (runs_so_far !== want.runs)
          report_mismatch("runs_so_far", 64'(runs_so_far), 64'(want.runs));
        if (end_cause !== want.cause)
          report_mismatch("end_cause", 64'(end_cause), 64'(want.cause));
        if (last_result !== want.last)
          report_mismatch("last_result", 64'(last_result), 64'(want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: a stall pattern that changes mode whenever the low six bits of
  // stall_tick are zero, overridden by a long hold-off on request. The hold-off is counted here.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    stall_tick = stall_tick + 8'd1;
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (stall_tick[5:0] == 6'd0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= (stall_tick[2:0] < 3'd3);
      endcase
    end
  end

  // Watchdog: end the run when nothing has moved for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transfer for %0d cycles", $realtime, IdleLimit);
      $display("[data_run_list_decoder] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Offer one byte and hold it until the transfer; called on a rising edge.
  task automatic send_byte(logic [7:0] b, logic fin);
    list_byte  <= b;
    final_byte <= fin;
    if (!offering) begin
      offering = 1'b1;
      in_valid <= 1'b1;
    end
    do @(posedge clk); while (in_stall);
    decode_list_byte(b, fin);
  endtask

  task automatic stop_offering();
    if (offering) begin
      offering = 1'b0;
      in_valid <= 1'b0;
    end
  endtask

  // Bursts of random length separated by short gaps, when gaps are enabled.
  task automatic pace_sender();
    if (!gaps_on) return;
    if (burst_left == 0) begin
      stop_offering();
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  // Send the built list, final flag on its last byte, then clear it.
  task automatic send_list();
    for (int i = 0; i < list_bytes.size(); i++) begin
      send_byte(list_bytes[i], i == list_bytes.size() - 1);
      pace_sender();
    end
    list_bytes.delete();
  endtask

  // Stop offering and wait until every result due has arrived, plus a margin
  // for bytes that the block swallows without a result.
  task automatic drain_results();
    stop_offering();
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_run_limit(logic [6:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = value;
  endtask

  // Field bytes lean toward the values that matter for sign and carry.
  function automatic logic [7:0] field_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int pick_len_bytes();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 4);
    if (r < 18) return $urandom_range(5, 8);
    return $urandom_range(9, 15);
  endfunction

  function automatic int pick_off_bytes();
    int r;
    r = $urandom_range(0, 19);
    if (r < 3) return 0;
    if (r < 15) return $urandom_range(1, 4);
    if (r < 18) return $urandom_range(5, 8);
    return $urandom_range(9, 15);
  endfunction

  task automatic append_run(int len_n, int off_n);
    list_bytes.push_back({4'(off_n), 4'(len_n)});
    repeat (len_n) list_bytes.push_back(field_byte());
    repeat (off_n) list_bytes.push_back(field_byte());
  endtask

  function automatic logic [6:0] pick_run_limit();
    case ($urandom_range(0, 11))
      0:       return 7'd1;
      1:       return 7'd64;
      2:       return 7'd0;
      3:       return 7'd127;
      4:       return 7'd2;
      default: return 7'($urandom_range(1, 64));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Field extremes and each way a list can end, apart from the run limit.
  task automatic test_directed();
    list_bytes = '{8'h00};                      // empty list: zero header
    send_list();
    list_bytes = '{8'h30, 8'hAA, 8'h55};        // zero length nibble, trailing bytes dropped
    send_list();
    list_bytes = '{8'h21};                      // final flag on a header
    send_list();
    list_bytes = '{8'h12, 8'h07};               // final flag inside the length field
    send_list();
    // negative one-byte offset, then a run with no offset, ending on the final byte
    list_bytes = '{8'h11, 8'hFF, 8'h80, 8'h01, 8'h05};
    send_list();
    // nine offset bytes: the ninth is dropped, bit 63 is the sign
    list_bytes = '{8'h91, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h00, 8'h80, 8'h7F, 8'h00};
    send_list();
  endtask

  // Lists longer than the limit, at the extremes of the register.
  task automatic test_run_limit();
    logic [6:0] limits[5];
    int         n_runs;
    limits = '{7'd1, 7'd0, 7'd64, 7'd127, 7'($urandom_range(2, 63))};
    foreach (limits[i]) begin
      set_run_limit(limits[i]);
      n_runs = ((limits[i] < 7'(MaxRuns)) ? int'(limits[i]) : MaxRuns) + 2;
      for (int r = 0; r < n_runs; r++) append_run(1, $urandom_range(0, 1));
      list_bytes.push_back(8'h00);
      send_list();
      // one list of a single run, which the limit cuts off only when it is zero
      append_run(pick_len_bytes(), pick_off_bytes());
      list_bytes.push_back(8'h00);
      send_list();
    end
  endtask

  // Mostly well-formed lists with random content and endings, some noise.
  task automatic test_random_lists();
    int n_runs;
    int ending;
    int len_n;
    int off_n;
    int list_no;
    list_no = 0;
    while (bytes_decoded < RandBytes) begin
      list_no++;
      gaps_on = ($urandom_range(0, 3) != 0);
      if (list_no % 12 == 0) set_run_limit(pick_run_limit());
      else if (list_no % 7 == 0) drain_results();
      if ($urandom_range(0, 6) == 0) begin
        // noise: raw bytes, whatever they decode to
        repeat ($urandom_range(1, 12)) list_bytes.push_back(8'($urandom));
      end else begin
        n_runs = $urandom_range(0, 5);
        if ($urandom_range(0, 9) == 0) n_runs = $urandom_range(6, 20);
        for (int r = 0; r < n_runs; r++) append_run(pick_len_bytes(), pick_off_bytes());
        ending = $urandom_range(0, 9);
        if (ending < 3) begin
          list_bytes.push_back(8'h00);
          repeat ($urandom_range(0, 3)) list_bytes.push_back(8'($urandom));
        end else if (ending < 6 && n_runs > 0) begin
          // end on the last byte of the last run
        end else if (ending < 8) begin
          // cut a run short anywhere before its last byte
          len_n = pick_len_bytes();
          off_n = pick_off_bytes();
          list_bytes.push_back({4'(off_n), 4'(len_n)});
          repeat ($urandom_range(0, len_n + off_n - 1)) list_bytes.push_back(field_byte());
        end else begin
          list_bytes.push_back({4'($urandom_range(1, 15)), 4'h0});
          repeat ($urandom_range(0, 3)) list_bytes.push_back(8'($urandom));
        end
      end
      send_list();
    end
    gaps_on = 1'b1;
  endtask

  // Hold the result side off while bytes keep coming, so the block fills up
  // and stalls its input; then drain.
  task automatic test_result_backpressure();
    set_run_limit(7'd64);
    gaps_on      = 1'b0;
    hold_request = 1'b1;
    repeat (6) begin
      repeat (6) append_run(1, $urandom_range(0, 2));
      list_bytes.push_back(8'h00);
      send_list();
    end
    gaps_on = 1'b1;
    drain_results();
  endtask

  initial begin
    restart_list();
    limit_reg     = 7'd64;
    bytes_decoded = 0;
    error_count   = 0;
    offering      = 1'b0;
    gaps_on       = 1'b1;
    burst_left    = 0;
    hold_request  = 1'b0;
    hold_left     = 0;
    stall_mode    = 0;
    stall_tick    = '0;
    idle_cycles   = 0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_run_limit();
    bytes_decoded = 0;
    set_run_limit(pick_run_limit());
    test_random_lists();
    test_result_backpressure();

    // Everything sent: wait for the last results, then a short tail.
    stop_offering();
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("[data_run_list_decoder] OK");
    end else begin
      $display("[data_run_list_decoder] ERROR");
    end
    $finish;
  end

endmodule
